// ===== rtl/ahhrf_pkg.sv =====
// ----------------------------------------------------------------------------
// ahhrf_pkg
// Types, character codes and digit conversion for the hex HID report framer.
// ----------------------------------------------------------------------------
package ahhrf_pkg;

  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_ONE    = 8'h31;
  localparam logic [7:0] CHAR_TWO    = 8'h32;
  localparam logic [7:0] CHAR_THREE  = 8'h33;
  localparam logic [7:0] ALPHA_LIMIT = 8'h40;
  localparam logic [7:0] NUM_BASE    = 8'h30;
  localparam logic [7:0] ALPHA_BASE  = 8'h37;
  localparam logic [7:0] ALPHA_BASE2 = 8'd110;
  localparam logic [7:0] ALPHA_BASE3 = 8'd165;
  localparam logic [7:0] ALPHA_BASE4 = 8'd220;

  localparam logic [1:0] KIND_KEYBOARD = 2'd1;
  localparam logic [1:0] KIND_MEDIA    = 2'd2;
  localparam logic [1:0] KIND_MOUSE    = 2'd3;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
    logic       rel_follow;
    logic [1:0] rel_kind;
    logic [3:0] rel_zeros;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic busy;
    logic out_valid;
  } back_status_t;

  function automatic logic [5:0] digit_value(input logic [7:0] c);
    logic [7:0] r;
    if (c < ALPHA_LIMIT) begin
      r = (c >= NUM_BASE) ? c - NUM_BASE : c;
    end else if (c >= ALPHA_BASE4) begin
      r = c - ALPHA_BASE4;
    end else if (c >= ALPHA_BASE3) begin
      r = c - ALPHA_BASE3;
    end else if (c >= ALPHA_BASE2) begin
      r = c - ALPHA_BASE2;
    end else begin
      r = c - ALPHA_BASE;
    end
    return r[5:0];
  endfunction

endpackage

// ===== rtl/ahhrf_front.sv =====
// ----------------------------------------------------------------------------
// ahhrf_front
// Command parser: hold flag, report type, hex digit pairs to report bytes.
// ----------------------------------------------------------------------------
module ahhrf_front #(
  parameter int KEYBOARD_BYTES = 9,
  parameter int MOUSE_BYTES    = 5,
  parameter int MEDIA_BYTES    = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        char_in,
  input  logic              cmd_start,
  output logic              wr_en,
  output ahhrf_pkg::cmd_t   wr_data
);

  localparam logic [3:0] KB_SIZE    = 4'(KEYBOARD_BYTES);
  localparam logic [3:0] MOUSE_SIZE = 4'(MOUSE_BYTES);
  localparam logic [3:0] MEDIA_SIZE = 4'(MEDIA_BYTES);

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_TYPE,
    PH_HIGH,
    PH_LOW
  } phase_t;

  phase_t     phase, phase_next;
  logic       hold, hold_next;
  logic [1:0] kind, kind_next;
  logic [3:0] size, size_next;
  logic [3:0] left, left_next;
  logic [7:0] high, high_next;
  logic [5:0] dv;
  logic [3:0] left_dec;

  assign dv       = ahhrf_pkg::digit_value(char_in);
  assign left_dec = left - 4'd1;

  always_comb begin
    phase_next = phase;
    hold_next  = hold;
    kind_next  = kind;
    size_next  = size;
    left_next  = left;
    high_next  = high;
    wr_en      = 1'b0;
    wr_data    = '0;
    if (accept) begin
      if (cmd_start || phase == PH_FLAG) begin
        hold_next  = (char_in != ahhrf_pkg::CHAR_ZERO);
        phase_next = PH_TYPE;
      end else begin
        case (phase)
          PH_TYPE: begin
            wr_en = 1'b1;
            case (char_in)
              ahhrf_pkg::CHAR_ONE: begin
                kind_next = ahhrf_pkg::KIND_KEYBOARD;
                size_next = KB_SIZE;
              end
              ahhrf_pkg::CHAR_TWO: begin
                kind_next = ahhrf_pkg::KIND_MEDIA;
                size_next = MEDIA_SIZE;
              end
              ahhrf_pkg::CHAR_THREE: begin
                kind_next = ahhrf_pkg::KIND_MOUSE;
                size_next = MOUSE_SIZE;
              end
              default: begin
                wr_data.bad  = 1'b1;
              end
            endcase
            if (wr_data.bad) begin
              wr_data.last = 1'b1;
              phase_next   = PH_FLAG;
            end else begin
              left_next    = size_next - 4'd1;
              wr_data.data = {6'b0, kind_next};
              wr_data.last = (left_next == 4'd0);
              phase_next   = (left_next == 4'd0) ? PH_FLAG : PH_HIGH;
            end
          end
          PH_HIGH: begin
            high_next  = {dv[3:0], 4'h0};
            phase_next = PH_LOW;
          end
          PH_LOW: begin
            wr_en              = 1'b1;
            left_next          = left_dec;
            wr_data.data       = high + {2'b0, dv};
            wr_data.last       = (left_dec == 4'd0);
            wr_data.rel_follow = (left_dec == 4'd0) && !hold;
            wr_data.rel_kind   = kind;
            wr_data.rel_zeros  = size - 4'd1;
            phase_next         = (left_dec == 4'd0) ? PH_FLAG : PH_HIGH;
          end
          default: begin
            phase_next = PH_FLAG;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FLAG;
      hold  <= 1'b0;
      kind  <= 2'd0;
      size  <= 4'd0;
      left  <= 4'd0;
      high  <= 8'd0;
    end else begin
      phase <= phase_next;
      hold  <= hold_next;
      kind  <= kind_next;
      size  <= size_next;
      left  <= left_next;
      high  <= high_next;
    end
  end

endmodule

// ===== rtl/ahhrf_queue.sv =====
// ----------------------------------------------------------------------------
// ahhrf_queue
// Short command queue between the parser and the report emitter.
// ----------------------------------------------------------------------------
module ahhrf_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  ahhrf_pkg::cmd_t        wr_data,
  input  logic                   rd_en,
  output ahhrf_pkg::cmd_t        rd_data,
  output ahhrf_pkg::q_status_t   status
);

  ahhrf_pkg::cmd_t                 mem [ahhrf_pkg::QUEUE_DEPTH];
  logic [ahhrf_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [ahhrf_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [ahhrf_pkg::QUEUE_AW:0]   count;

  assign rd_data      = mem[rd_ptr];
  assign status.empty = (count == '0);
  assign status.full  = (count == (ahhrf_pkg::QUEUE_AW+1)'(ahhrf_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/ahhrf_back.sv =====
// ----------------------------------------------------------------------------
// ahhrf_back
// Report emitter: output register plus release report burst generator.
// ----------------------------------------------------------------------------
module ahhrf_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pop,
  input  ahhrf_pkg::cmd_t           rd_data,
  input  ahhrf_pkg::q_status_t      q_status,
  output logic                      rd_en,
  output logic [7:0]                report_byte,
  output logic                      report_end,
  output logic                      is_release,
  output logic                      bad_type,
  output ahhrf_pkg::back_status_t   status
);

  logic       out_valid;
  logic       id_pending;
  logic [3:0] zeros_left;
  logic [1:0] burst_kind;
  logic       load;
  logic       busy;

  assign load             = !out_valid || pop;
  assign busy             = id_pending || (zeros_left != 4'd0);
  assign rd_en            = load && !busy && !q_status.empty;
  assign status.busy      = busy;
  assign status.out_valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      id_pending <= 1'b0;
      zeros_left <= 4'd0;
    end else if (load) begin
      if (id_pending) begin
        out_valid   <= 1'b1;
        id_pending  <= 1'b0;
        report_byte <= {6'b0, burst_kind};
        report_end  <= (zeros_left == 4'd0);
        is_release  <= 1'b1;
        bad_type    <= 1'b0;
      end else if (zeros_left != 4'd0) begin
        out_valid   <= 1'b1;
        zeros_left  <= zeros_left - 4'd1;
        report_byte <= 8'h00;
        report_end  <= (zeros_left == 4'd1);
        is_release  <= 1'b1;
        bad_type    <= 1'b0;
      end else if (!q_status.empty) begin
        out_valid   <= 1'b1;
        id_pending  <= rd_data.rel_follow;
        zeros_left  <= rd_data.rel_follow ? rd_data.rel_zeros : 4'd0;
        burst_kind  <= rd_data.rel_kind;
        report_byte <= rd_data.data;
        report_end  <= rd_data.last;
        is_release  <= 1'b0;
        bad_type    <= rd_data.bad;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/ascii_hex_hid_report_framer_unit.sv =====
// ----------------------------------------------------------------------------
// ascii_hex_hid_report_framer_unit
// Frames ASCII hex commands into HID report bytes, with release reports.
//
//   channel  ports                                             handshake
//   chars    char_in, cmd_start                                push / full
//   reports  report_byte, report_end, is_release, bad_type     pop / empty
//
// One character is taken per cycle while the command queue has room.
// Each report byte leaves through the output register, one per cycle
// while pop is held; a release report keeps the emitter busy while the
// four-entry queue soaks up parsed bytes. A report byte passes through
// the queue and then the output register on its way to the result ports.
// Synchronous reset empties the queue and output.
// ----------------------------------------------------------------------------
module ascii_hex_hid_report_framer_unit #(
  parameter int KEYBOARD_BYTES = 9,
  parameter int MOUSE_BYTES    = 5,
  parameter int MEDIA_BYTES    = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in,
  input  logic       cmd_start,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] report_byte,
  output logic       report_end,
  output logic       is_release,
  output logic       bad_type
);

  ahhrf_pkg::cmd_t         wr_data;
  ahhrf_pkg::cmd_t         rd_data;
  ahhrf_pkg::q_status_t    q_stat;
  ahhrf_pkg::back_status_t bk_stat;
  logic                    accept;
  logic                    wr_en;
  logic                    rd_en;

  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;
  assign empty  = !bk_stat.out_valid;

  ahhrf_front #(
    .KEYBOARD_BYTES (KEYBOARD_BYTES),
    .MOUSE_BYTES    (MOUSE_BYTES),
    .MEDIA_BYTES    (MEDIA_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_in   (char_in),
    .cmd_start (cmd_start),
    .wr_en     (wr_en),
    .wr_data   (wr_data)
  );

  ahhrf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_data (rd_data),
    .status  (q_stat)
  );

  ahhrf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop         (pop),
    .rd_data     (rd_data),
    .q_status    (q_stat),
    .rd_en       (rd_en),
    .report_byte (report_byte),
    .report_end  (report_end),
    .is_release  (is_release),
    .bad_type    (bad_type),
    .status      (bk_stat)
  );

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && bad_type) |-> (report_end && !is_release && report_byte == 8'h00))
    else $error("error item malformed");

  a_queue_drains: assert property (@(posedge clk) disable iff (rst)
    (!q_stat.empty && !bk_stat.busy && !bk_stat.out_valid) |=> !empty)
    else $error("queued item not moved to output");

  a_burst_start: assert property (@(posedge clk) disable iff (rst)
    $rose(bk_stat.busy) |-> (!empty && !is_release && report_end))
    else $error("release burst started without closing data item");

endmodule

// ===== bench/ascii_hex_hid_report_framer_check.sv =====
// ----------------------------------------------------------------------------
// ascii_hex_hid_report_framer_check
// Watches the character and report channels of the hex HID report framer.
// Each accepted character runs through a cycle-free model of the command
// parser. The model queues the report bytes it predicts, and every popped
// report byte is compared with the oldest of them. The failure count and the
// number of report bytes still awaited go back to the bench top.
// ----------------------------------------------------------------------------
module ascii_hex_hid_report_framer_check #(
  parameter int KEYBOARD_BYTES = 9,
  parameter int MOUSE_BYTES    = 5,
  parameter int MEDIA_BYTES    = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] char_in,
  input  logic       cmd_start,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] report_byte,
  input  logic       report_end,
  input  logic       is_release,
  input  logic       bad_type,
  output int         fails,
  output int         pending
);

  typedef enum logic [1:0] {
    WAIT_HOLD,
    WAIT_KIND,
    WAIT_HIGH,
    WAIT_LOW
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       rel;
    logic       bad;
  } report_t;

  phase_t     phase;
  logic       hold;
  logic [1:0] kind;
  logic [3:0] left;
  logic [7:0] high;
  report_t    report_q[$];
  int         mismatches;

  function automatic logic [7:0] digit_of(input logic [7:0] c);
    return (c < ahhrf_pkg::ALPHA_LIMIT) ? c % ahhrf_pkg::NUM_BASE
                                        : c % ahhrf_pkg::ALPHA_BASE;
  endfunction

  function automatic logic [3:0] size_of(input logic [1:0] k);
    if (k == ahhrf_pkg::KIND_KEYBOARD) return 4'(KEYBOARD_BYTES);
    if (k == ahhrf_pkg::KIND_MEDIA) return 4'(MEDIA_BYTES);
    return 4'(MOUSE_BYTES);
  endfunction

  task automatic queue_report(input logic [7:0] d, input logic l, input logic r,
                              input logic b);
    report_q.push_back('{data: d, last: l, rel: r, bad: b});
  endtask

  task automatic frame_char(input logic [7:0] c, input logic s);
    logic [7:0] b;
    logic [3:0] size;
    logic       known;
    int         i;
    if (s || phase == WAIT_HOLD) begin
      hold  = (c != ahhrf_pkg::CHAR_ZERO);
      phase = WAIT_KIND;
    end else if (phase == WAIT_KIND) begin
      known = 1'b1;
      if (c == ahhrf_pkg::CHAR_ONE) kind = ahhrf_pkg::KIND_KEYBOARD;
      else if (c == ahhrf_pkg::CHAR_TWO) kind = ahhrf_pkg::KIND_MEDIA;
      else if (c == ahhrf_pkg::CHAR_THREE) kind = ahhrf_pkg::KIND_MOUSE;
      else known = 1'b0;
      if (!known) begin
        queue_report(8'h00, 1'b1, 1'b0, 1'b1);
        phase = WAIT_HOLD;
      end else begin
        size = size_of(kind);
        left = size - 4'd1;
        queue_report({6'b0, kind}, left == 4'd0, 1'b0, 1'b0);
        phase = (left == 4'd0) ? WAIT_HOLD : WAIT_HIGH;
      end
    end else if (phase == WAIT_HIGH) begin
      high  = digit_of(c) << 4;
      phase = WAIT_LOW;
    end else begin
      b    = high + digit_of(c);
      left = left - 4'd1;
      queue_report(b, left == 4'd0, 1'b0, 1'b0);
      if (left != 4'd0) begin
        phase = WAIT_HIGH;
      end else begin
        phase = WAIT_HOLD;
        if (!hold) begin
          size = size_of(kind);
          queue_report({6'b0, kind}, size <= 4'd1, 1'b1, 1'b0);
          for (i = 1; i < size; i++) queue_report(8'h00, i == size - 1, 1'b1, 1'b0);
        end
      end
    end
  endtask

  task automatic check_report();
    report_t want;
    if (report_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected report byte: byte %02h end %b release %b bad %b",
                 report_byte, report_end, is_release, bad_type);
    end else begin
      want = report_q.pop_front();
      if (report_byte !== want.data || report_end !== want.last ||
          is_release !== want.rel || bad_type !== want.bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("report mismatch: expected %02h/%b/%b/%b got %02h/%b/%b/%b",
                   want.data, want.last, want.rel, want.bad,
                   report_byte, report_end, is_release, bad_type);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase      = WAIT_HOLD;
      hold       = 1'b0;
      kind       = 2'd0;
      left       = 4'd0;
      high       = 8'h00;
      mismatches = 0;
      report_q.delete();
    end else begin
      if (pop && !empty) check_report();
      if (push && !full) frame_char(char_in, cmd_start);
    end
    fails   <= mismatches;
    pending <= report_q.size();
  end

endmodule

// ===== bench/ascii_hex_hid_report_framer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// ascii_hex_hid_report_framer_unit_tb
// Drives command characters into the hex HID report framer: a short directed
// run over release, hold, unknown type, restart and commands that start
// without a start mark, then mostly well-formed random commands mixed with
// truncated ones and noise. Both channels stall at random. The checker
// beside the block predicts and compares every report byte.
// ----------------------------------------------------------------------------
module ascii_hex_hid_report_framer_unit_tb;

  localparam int KEYBOARD_BYTES = 9;
  localparam int MOUSE_BYTES    = 5;
  localparam int MEDIA_BYTES    = 2;
  localparam int CHAR_TOTAL     = 465;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       push      = 1'b0;
  logic [7:0] char_in   = 8'h00;
  logic       cmd_start = 1'b0;
  logic       pop       = 1'b0;
  logic       steady    = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] report_byte;
  logic       report_end;
  logic       is_release;
  logic       bad_type;
  int         fails;
  int         pending;
  int         sent      = 0;
  int         pop_wait  = 0;
  bit         paused    = 1'b0;

  ascii_hex_hid_report_framer_unit #(
    .KEYBOARD_BYTES(KEYBOARD_BYTES),
    .MOUSE_BYTES   (MOUSE_BYTES),
    .MEDIA_BYTES   (MEDIA_BYTES)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .char_in    (char_in),
    .cmd_start  (cmd_start),
    .empty      (empty),
    .pop        (pop),
    .report_byte(report_byte),
    .report_end (report_end),
    .is_release (is_release),
    .bad_type   (bad_type)
  );

  ascii_hex_hid_report_framer_check #(
    .KEYBOARD_BYTES(KEYBOARD_BYTES),
    .MOUSE_BYTES   (MOUSE_BYTES),
    .MEDIA_BYTES   (MEDIA_BYTES)
  ) report_check (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .char_in    (char_in),
    .cmd_start  (cmd_start),
    .empty      (empty),
    .pop        (pop),
    .report_byte(report_byte),
    .report_end (report_end),
    .is_release (is_release),
    .bad_type   (bad_type),
    .fails      (fails),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] pick_digit();
    logic [3:0] v;
    v = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 11))
      0:       return 8'($urandom_range(0, 255));
      1:       return (v < 10) ? ahhrf_pkg::NUM_BASE + v
                               : ahhrf_pkg::ALPHA_BASE + 8'h20 + v;
      default: return (v < 10) ? ahhrf_pkg::NUM_BASE + v : ahhrf_pkg::ALPHA_BASE + v;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pop      <= 1'b0;
      pop_wait <= 0;
    end else if (pop_wait != 0) begin
      pop      <= 1'b0;
      pop_wait <= pop_wait - 1;
    end else begin
      pop <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) pop_wait <= gap_len();
    end
  end

  task automatic send_char(input logic [7:0] c, input logic s);
    int gap;
    gap = (!steady && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push      <= 1'b1;
    char_in   <= c;
    cmd_start <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_command();
    logic [7:0] hold_c;
    logic [7:0] kind_c;
    int         pairs;
    int         cut;
    int         i;
    case ($urandom_range(0, 3))
      0, 1:    hold_c = ahhrf_pkg::CHAR_ZERO;
      2:       hold_c = ahhrf_pkg::CHAR_ONE;
      default: hold_c = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: kind_c = ahhrf_pkg::CHAR_ONE;
      3, 4, 5: kind_c = ahhrf_pkg::CHAR_TWO;
      6, 7, 8: kind_c = ahhrf_pkg::CHAR_THREE;
      default: kind_c = 8'($urandom_range(0, 255));
    endcase
    if (kind_c == ahhrf_pkg::CHAR_ONE) pairs = KEYBOARD_BYTES - 1;
    else if (kind_c == ahhrf_pkg::CHAR_TWO) pairs = MEDIA_BYTES - 1;
    else if (kind_c == ahhrf_pkg::CHAR_THREE) pairs = MOUSE_BYTES - 1;
    else pairs = 0;
    cut = ($urandom_range(0, 7) == 0 && pairs != 0) ? $urandom_range(0, 2 * pairs - 1)
                                                  : 2 * pairs;
    send_char(hold_c, $urandom_range(0, 5) != 0);
    send_char(kind_c, 1'b0);
    for (i = 0; i < cut; i++) send_char(pick_digit(), 1'b0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // media report with release, extreme digit codes
    send_char(ahhrf_pkg::CHAR_ZERO, 1'b1);
    send_char(ahhrf_pkg::CHAR_TWO, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b0);
    // mouse report held, cut short by a restart
    send_char(8'h00, 1'b1);
    send_char(ahhrf_pkg::CHAR_THREE, 1'b0);
    send_char("F", 1'b0);
    send_char("F", 1'b0);
    send_char("0", 1'b0);
    send_char("0", 1'b0);
    send_char("9", 1'b0);
    // unknown type
    send_char(ahhrf_pkg::CHAR_ONE, 1'b1);
    send_char(8'h7E, 1'b0);
    // next command without a start mark
    send_char("5", 1'b0);
    send_char(ahhrf_pkg::CHAR_TWO, 1'b0);
    send_char("7", 1'b0);
    send_char("a", 1'b0);
    // keyboard report with release
    send_char(ahhrf_pkg::CHAR_ZERO, 1'b1);
    send_char(ahhrf_pkg::CHAR_ONE, 1'b0);
    repeat (16) send_char(pick_digit(), 1'b0);

    while (sent < CHAR_TOTAL) begin
      steady <= (sent >= 120 && sent < 200);
      if (!paused && sent >= 250) begin
        paused = 1'b1;
        drain();
      end
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 4))
          send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      else
        random_command();
    end

    drain();
    repeat (10) @(posedge clk);
    if (fails == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #10000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
